>>> rtl/core/hkm_pkg.sv
package hkm_pkg;

	// Default sizes
	localparam int TRAIN_MAX_DEF = 1024;
	localparam int K_MAX_DEF     = 8;

	// Fixed field widths
	localparam int DESC_W   = 256;
	localparam int WORD_W   = 64;
	localparam int NWORDS   = DESC_W / WORD_W;
	localparam int POP_W    = 7;
	localparam int DIST_W   = 9;
	localparam int QIDX_W   = 16;
	localparam int RANK_W   = 3;
	localparam int TIDX_W   = 10;
	localparam int CMD_W    = 2;
	localparam int KREG_W   = 4;
	localparam int OUT_W    = QIDX_W + RANK_W + TIDX_W + DIST_W;
	localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8;

	localparam logic [KREG_W-1:0] K_RESET = KREG_W'(2);

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// Bit count of one 64-bit word, folded in pairs, nibbles, bytes, then up
	function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
		logic [WORD_W-1:0] e;
		logic [WORD_W-1:0] f;
		a = v - ((v >> 1) & 64'h5555_5555_5555_5555);
		b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
		c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
		d = c + (c >> 8);
		e = d + (d >> 16);
		f = e + (e >> 32);
		return f[POP_W-1:0];
	endfunction

endpackage

>>> rtl/core/hkm_scan.sv
module hkm_scan import hkm_pkg::*; #(
	parameter int TRAIN_MAX = TRAIN_MAX_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [$clog2(TRAIN_MAX)-1:0] wr_addr,
	input  logic [DESC_W-1:0]            wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(TRAIN_MAX)-1:0] rd_addr,
	input  logic [DESC_W-1:0]            query,
	output logic                         busy,
	output logic                         dist_vld,
	output logic [$clog2(TRAIN_MAX)-1:0] dist_idx,
	output logic [DIST_W-1:0]            hdist
);

	localparam int IW = $clog2(TRAIN_MAX);

	logic [DESC_W-1:0] mem [TRAIN_MAX];

	logic [DESC_W-1:0]            rdata_s1;
	logic                         vld_s1;
	logic [IW-1:0]                idx_s1;
	logic [POP_W-1:0]             pop_s2 [NWORDS];
	logic                         vld_s2;
	logic [IW-1:0]                idx_s2;
	logic [DIST_W-1:0]            dist_s3;
	logic                         vld_s3;
	logic [IW-1:0]                idx_s3;
	logic [DESC_W-1:0]            diff;

	// Writes happen only while no scan runs, so read and write never collide
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	assign diff = rdata_s1 ^ query;

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		for (int w = 0; w < NWORDS; w++) begin
			pop_s2[w] <= pop64(diff[w*WORD_W +: WORD_W]);
		end
		dist_s3 <= DIST_W'(pop_s2[0]) + DIST_W'(pop_s2[1])
			+ DIST_W'(pop_s2[2]) + DIST_W'(pop_s2[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign busy     = vld_s1 | vld_s2 | vld_s3;
	assign dist_vld = vld_s3;
	assign dist_idx = idx_s3;
	assign hdist    = dist_s3;

endmodule

>>> rtl/core/hamming_knn_descriptor_matcher.sv
// Brute-force k-nearest matcher for 256-bit binary descriptors.
// Input stream (s_*): s_tuser carries the command (clear, append, query),
// s_tdata the descriptor. Clear resets the train set and the query counter,
// append stores one descriptor (dropped when the store is full), query
// reports the k nearest stored descriptors.
// Output stream (m_*): one transaction per neighbor, nearest first; ties go
// to the lower train index, and m_tlast marks the final one of a query.
// cfg_* writes k_neighbors (reset value 2), capped at K_MAX and at the
// number of stored descriptors; cfg_ready is always high.
// Clear and append are taken while idle. A query is accepted, then scans
// train_count descriptors (one memory read per cycle from the train
// memory) through the read and distance pipeline, closes the scan, then
// emits k results. A query with no results is accepted without a scan.
// One item is handled at a time: s_tready is low during scan and output.
// When the receiver stalls, the current result holds on m_tdata and the
// block waits. Reset empties the train set and zeroes the query counter;
// the train memory itself is not cleared and needs no clearing pass.
module hamming_knn_descriptor_matcher import hkm_pkg::*; #(
	parameter int TRAIN_MAX = TRAIN_MAX_DEF,
	parameter int K_MAX     = K_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DESC_W-1:0] s_tdata,  // desc_w0, desc_w1, desc_w2, desc_w3
	input  logic [CMD_W-1:0]  s_tuser,  // cmd
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata,  // query_index, rank, train_index, distance
	output logic              m_tlast,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [KREG_W-1:0] cfg_data
);

	localparam int IW = $clog2(TRAIN_MAX);
	localparam int CW = $clog2(TRAIN_MAX + 1);
	localparam int KW = $clog2(K_MAX + 1);
	localparam int RW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

	state_t state_q, state_d;

	logic [KREG_W-1:0] k_q;
	logic [KW-1:0]     k_eff_q;
	logic [KW-1:0]     k_new;
	logic [CW-1:0]     train_count_q;
	logic [QIDX_W-1:0] query_count_q;
	logic [QIDX_W-1:0] qi_q;
	logic [DESC_W-1:0] query_q;
	logic [CW-1:0]     scan_cnt_q;
	logic [RW-1:0]     rank_q;

	logic [DIST_W-1:0] best_dist_q [K_MAX];
	logic [IW-1:0]     best_idx_q  [K_MAX];
	logic [K_MAX-1:0]  best_vld_q;
	logic [DIST_W-1:0] best_dist_d [K_MAX];
	logic [IW-1:0]     best_idx_d  [K_MAX];
	logic [K_MAX-1:0]  best_vld_d;
	logic [K_MAX:0]    stay_ext;

	logic              in_xfer;
	logic              out_xfer;
	logic              issue;
	logic              scan_done;
	logic              emit_last;
	logic              busy;
	logic              dist_vld;
	logic [IW-1:0]     dist_idx;
	logic [DIST_W-1:0] hdist;
	logic              wr_en;
	cmd_t              cmd;

	logic [TIDX_W+IW-1:0] tidx_ext;
	logic [TIDX_W-1:0]    tidx;

	assign cmd       = cmd_t'(s_tuser);
	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign out_xfer  = m_tvalid && m_tready;
	assign scan_done = (scan_cnt_q == train_count_q) && !busy;
	assign emit_last = (KW'(rank_q) + KW'(1)) == k_eff_q;
	assign wr_en     = in_xfer && (cmd == CMD_APPEND) && (train_count_q != CW'(TRAIN_MAX));

	always_comb begin
		int kc;
		kc = int'(k_q);
		if (kc > K_MAX) begin
			kc = K_MAX;
		end
		if (kc > int'(train_count_q)) begin
			kc = int'(train_count_q);
		end
		k_new = KW'(kc);
	end

	hkm_scan #(
		.TRAIN_MAX(TRAIN_MAX)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (train_count_q[IW-1:0]),
		.wr_data (s_tdata),
		.rd_en   (issue),
		.rd_addr (scan_cnt_q[IW-1:0]),
		.query   (query_q),
		.busy    (busy),
		.dist_vld(dist_vld),
		.dist_idx(dist_idx),
		.hdist   (hdist)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer && cmd == CMD_QUERY && k_new != '0) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_xfer && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: issue = (scan_cnt_q != train_count_q);
			ST_EMIT: m_tvalid = 1'b1;
			default: s_tready = 1'b0;
		endcase
	end

	// Sorted insertion: entries at or below the new distance stay, the rest shift down
	always_comb begin
		for (int i = 0; i < K_MAX; i++) begin
			stay_ext[i + 1] = best_vld_q[i] && (best_dist_q[i] <= hdist);
			best_dist_d[i]  = best_dist_q[i];
			best_idx_d[i]   = best_idx_q[i];
			best_vld_d[i]   = best_vld_q[i];
		end
		stay_ext[0] = 1'b1;
		for (int i = 0; i < K_MAX; i++) begin
			if (!stay_ext[i + 1] && stay_ext[i]) begin
				best_dist_d[i] = hdist;
				best_idx_d[i]  = dist_idx;
				best_vld_d[i]  = 1'b1;
			end
		end
		for (int i = 1; i < K_MAX; i++) begin
			if (!stay_ext[i]) begin
				best_dist_d[i] = best_dist_q[i - 1];
				best_idx_d[i]  = best_idx_q[i - 1];
				best_vld_d[i]  = best_vld_q[i - 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && cmd == CMD_QUERY) begin
			query_q <= s_tdata;
			qi_q    <= query_count_q;
			k_eff_q <= k_new;
		end
		if (dist_vld) begin
			for (int i = 0; i < K_MAX; i++) begin
				best_dist_q[i] <= best_dist_d[i];
				best_idx_q[i]  <= best_idx_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			k_q           <= K_RESET;
			train_count_q <= '0;
			query_count_q <= '0;
			scan_cnt_q    <= '0;
			rank_q        <= '0;
			best_vld_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				k_q <= cfg_data;
			end
			if (in_xfer) begin
				unique case (cmd)
					CMD_CLEAR: begin
						train_count_q <= '0;
						query_count_q <= '0;
					end
					CMD_APPEND: begin
						if (wr_en) begin
							train_count_q <= train_count_q + CW'(1);
						end
					end
					CMD_QUERY: begin
						query_count_q <= query_count_q + QIDX_W'(1);
						scan_cnt_q    <= '0;
						rank_q        <= '0;
						best_vld_q    <= '0;
					end
					default: ;
				endcase
			end
			if (issue) begin
				scan_cnt_q <= scan_cnt_q + CW'(1);
			end
			if (dist_vld) begin
				best_vld_q <= best_vld_d;
			end
			if (out_xfer) begin
				rank_q <= rank_q + RW'(1);
			end
		end
	end

	assign tidx_ext = {{TIDX_W{1'b0}}, best_idx_q[rank_q]};
	assign tidx     = tidx_ext[TIDX_W-1:0];

	assign m_tdata = {{(OUT_TW - OUT_W){1'b0}}, best_dist_q[rank_q], tidx,
		RANK_W'(rank_q), qi_q};
	assign m_tlast = emit_last;

	a_no_input_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while results pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		train_count_q <= CW'(TRAIN_MAX))
		else $error("train count beyond capacity");

	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (k_eff_q != '0) && (KW'(rank_q) < k_eff_q))
		else $error("rank outside reported range");

	a_list_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && state_d == ST_EMIT) |=>
			best_vld_q[RW'(k_eff_q - KW'(1))])
		else $error("best list shorter than k at end of scan");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && m_tlast) |=> s_tready && !m_tvalid)
		else $error("block did not return to idle after last result");

endmodule

>>> tb/sv/hamming_knn_descriptor_matcher_tb.sv
`timescale 1ns / 1ps

module hamming_knn_descriptor_matcher_tb;
	import hkm_pkg::*;

	localparam int unsigned RUN_LIMIT    = 400_000;
	localparam int unsigned HOLD_CYCLES  = 300;
	// Longest scan of a full train store, plus K_MAX and margin
	localparam int unsigned IDLE_SETTLE  = TRAIN_MAX_DEF + K_MAX_DEF + 64;
	localparam int unsigned RANDOM_ITEMS = 88;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [DESC_W-1:0] DESC_ZEROS = '0;
	localparam logic [DESC_W-1:0] DESC_ONES  = '1;
	localparam logic [DESC_W-1:0] DESC_ALT   = {64{4'b0101}};

	typedef struct packed {
		logic [QIDX_W-1:0] query_index;
		logic [RANK_W-1:0] rank;
		logic [TIDX_W-1:0] train_index;
		logic [DIST_W-1:0] distance;
		logic              last;
	} match_t;

	class neighbor_tracker;
		logic [DESC_W-1:0] train_mem [TRAIN_MAX_DEF];
		int unsigned       train_count;
		logic [QIDX_W-1:0] query_count;
		logic [KREG_W-1:0] k_reg;
		match_t            pending_matches [$];
		int unsigned       failures;

		function new();
			train_count = 0;
			query_count = '0;
			k_reg = K_RESET;
			failures = 0;
		endfunction

		function void set_k(logic [KREG_W-1:0] value);
			k_reg = value;
		endfunction

		function int unsigned outstanding();
			return pending_matches.size();
		endfunction

		function void note_item(logic [CMD_W-1:0] cmd, logic [DESC_W-1:0] desc);
			int unsigned k;
			int unsigned filled;
			int unsigned pos;
			int unsigned d;
			int unsigned j;
			int unsigned m;
			int unsigned best_d [K_MAX_DEF];
			int unsigned best_i [K_MAX_DEF];
			match_t r;
			case (cmd)
				CMD_CLEAR: begin
					train_count = 0;
					query_count = '0;
				end
				CMD_APPEND: begin
					// drop silently once the store is full
					if (train_count < TRAIN_MAX_DEF) begin
						train_mem[train_count] = desc;
						train_count++;
					end
				end
				CMD_QUERY: begin
					r.query_index = query_count;
					query_count++;
					k = k_reg;
					if (k > K_MAX_DEF)
						k = K_MAX_DEF;
					if (k > train_count)
						k = train_count;
					if (k != 0) begin
						filled = 0;
						for (j = 0; j < train_count; j++) begin
							d = $countones(desc ^ train_mem[j]);
							// a tie never displaces an earlier index
							if (filled == k && d >= best_d[k-1])
								continue;
							pos = 0;
							while (pos < filled && best_d[pos] <= d)
								pos++;
							if (filled < k)
								filled++;
							for (m = filled - 1; m > pos; m--) begin
								best_d[m] = best_d[m-1];
								best_i[m] = best_i[m-1];
							end
							best_d[pos] = d;
							best_i[pos] = j;
						end
						for (m = 0; m < k; m++) begin
							r.rank = m[RANK_W-1:0];
							r.train_index = best_i[m][TIDX_W-1:0];
							r.distance = best_d[m][DIST_W-1:0];
							r.last = (m + 1 == k);
							pending_matches.insert(pending_matches.size(), r);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_match(match_t got);
			match_t want;
			if (pending_matches.size() == 0) begin
				$error("unexpected match: query_index %0d rank %0d train_index %0d distance %0d",
					got.query_index, got.rank, got.train_index, got.distance);
				failures++;
				return;
			end
			want = pending_matches.pop_front();
			compare_field("query_index", want.query_index, got.query_index);
			compare_field("rank", want.rank, got.rank);
			compare_field("train_index", want.train_index, got.train_index);
			compare_field("distance", want.distance, got.distance);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [DESC_W-1:0] s_tdata   = '0;
	logic [CMD_W-1:0]  s_tuser   = CMD_CLEAR;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [OUT_TW-1:0] m_tdata;
	logic              m_tlast;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [KREG_W-1:0] cfg_data  = '0;

	neighbor_tracker   tracker;
	logic [DESC_W-1:0] train_copies [$];
	int unsigned       cycle_count     = 0;
	int unsigned       items_sent      = 0;
	int unsigned       send_gap_odds   = 0;
	int unsigned       recv_stall_odds = 0;
	bit                hold_outputs    = 1'b0;

	hamming_knn_descriptor_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("hamming_knn_descriptor_matcher_tb: FAIL");
			$finish;
		end
	end

	// Observe every transaction on the three channels
	always @(posedge clk) begin
		match_t seen;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_item(s_tuser, s_tdata);
			if (cfg_valid && cfg_ready)
				tracker.set_k(cfg_data);
			if (m_tvalid && m_tready) begin
				seen.query_index = m_tdata[QIDX_W-1:0];
				seen.rank = m_tdata[QIDX_W +: RANK_W];
				seen.train_index = m_tdata[QIDX_W+RANK_W +: TIDX_W];
				seen.distance = m_tdata[QIDX_W+RANK_W+TIDX_W +: DIST_W];
				seen.last = m_tlast;
				tracker.check_match(seen);
			end
		end
	end

	// Result receiver: random stall bursts, and one long hold on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_outputs) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_outputs = 1'b0;
				m_tready <= 1'b1;
			end else if (recv_stall_odds != 0 && $urandom_range(recv_stall_odds - 1, 0) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(11, 1)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [DESC_W-1:0] rand_desc();
		logic [DESC_W-1:0] v;
		for (int i = 0; i < DESC_W / 32; i++)
			v[i*32 +: 32] = $urandom;
		return v;
	endfunction

	function automatic logic [DESC_W-1:0] flip_bits(logic [DESC_W-1:0] v, int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			v[$urandom_range(DESC_W - 1, 0)] ^= 1'b1;
		return v;
	endfunction

	function automatic logic [DESC_W-1:0] stored_desc();
		return train_copies[$urandom_range(train_copies.size() - 1, 0)];
	endfunction

	function automatic int unsigned pick_odds();
		case ($urandom_range(3, 0))
			0: return 0;
			1: return 3;
			2: return 6;
			default: return 10;
		endcase
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DESC_W-1:0] desc);
		int unsigned gap;
		@(negedge clk);
		if (send_gap_odds != 0 && $urandom_range(send_gap_odds - 1, 0) == 0) begin
			gap = $urandom_range(11, 1);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= desc;
		do @(posedge clk); while (!s_tready);
		if (cmd != CMD_UNUSED)
			items_sent++;
		if (cmd == CMD_CLEAR)
			train_copies.delete();
		else if (cmd == CMD_APPEND)
			train_copies.insert(train_copies.size(), desc);
	endtask

	task automatic drain_matches();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
	endtask

	task automatic write_k(input logic [KREG_W-1:0] value);
		drain_matches();
		// wait in idle before k changes
		repeat (IDLE_SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned set_num;
		int unsigned n_app;
		int unsigned n_q;
		int unsigned pick;
		logic [DESC_W-1:0] d;

		tracker = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, k at its reset value first
		send_gap_odds = 4;
		recv_stall_odds = 4;
		send_item(CMD_QUERY, rand_desc());
		send_item(CMD_UNUSED, rand_desc());
		send_item(CMD_APPEND, DESC_ZEROS);
		send_item(CMD_APPEND, DESC_ONES);
		send_item(CMD_APPEND, DESC_ALT);
		send_item(CMD_APPEND, DESC_ZEROS);
		send_item(CMD_APPEND, ~DESC_ALT);
		send_item(CMD_QUERY, DESC_ZEROS);
		send_item(CMD_QUERY, DESC_ONES);
		send_item(CMD_QUERY, DESC_ALT);
		send_item(CMD_QUERY, flip_bits(DESC_ONES, 1));
		send_item(CMD_CLEAR, DESC_ONES);
		send_item(CMD_APPEND, DESC_ONES);
		send_item(CMD_QUERY, DESC_ZEROS);
		send_item(CMD_UNUSED, DESC_ZEROS);
		write_k(4'd8);
		send_item(CMD_QUERY, rand_desc());
		for (int i = 0; i < 8; i++)
			send_item(CMD_APPEND, rand_desc());
		send_item(CMD_QUERY, DESC_ZEROS);
		write_k(4'd0);
		send_item(CMD_QUERY, DESC_ONES);
		send_item(CMD_QUERY, DESC_ZEROS);
		write_k(4'd15);
		send_item(CMD_QUERY, DESC_ONES);
		write_k(4'd1);
		send_item(CMD_QUERY, rand_desc());

		// Random part: mostly load-then-query sets with random content
		set_num = 0;
		while (items_sent < RANDOM_ITEMS) begin
			send_gap_odds = pick_odds();
			recv_stall_odds = pick_odds();
			if (set_num > 0 && $urandom_range(2, 0) == 0) begin
				if ($urandom_range(4, 0) == 0)
					write_k(KREG_W'($urandom_range(15, 0)));
				else
					write_k(KREG_W'($urandom_range(8, 1)));
			end
			if (set_num == 3)
				drain_matches();
			if (train_copies.size() > 60 || $urandom_range(4, 0) != 0)
				send_item(CMD_CLEAR, rand_desc());
			n_app = ($urandom_range(5, 0) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
			for (int unsigned i = 0; i < n_app; i++) begin
				if ($urandom_range(9, 0) == 0)
					send_item(CMD_UNUSED, rand_desc());
				if (train_copies.size() != 0 && $urandom_range(2, 0) == 0)
					send_item(CMD_APPEND, flip_bits(stored_desc(), $urandom_range(6, 0)));
				else
					send_item(CMD_APPEND, rand_desc());
			end
			// stall the output long enough that queued queries back up the input
			if (set_num == 1)
				hold_outputs = 1'b1;
			n_q = $urandom_range(6, 2);
			for (int unsigned i = 0; i < n_q; i++) begin
				pick = $urandom_range(19, 0);
				if (pick < 12)
					d = flip_bits(stored_desc(), $urandom_range(20, 0));
				else if (pick < 17)
					d = rand_desc();
				else
					d = ~stored_desc();
				send_item(CMD_QUERY, d);
				if ($urandom_range(5, 0) == 0)
					send_item(CMD_APPEND, flip_bits(stored_desc(), $urandom_range(3, 0)));
			end
			set_num++;
		end

		// Last part, no idling: one short set back to back
		send_gap_odds = 0;
		recv_stall_odds = 0;
		write_k(4'd8);
		send_item(CMD_CLEAR, rand_desc());
		for (int i = 0; i < 10; i++) begin
			if (i > 0 && $urandom_range(3, 0) == 0)
				send_item(CMD_APPEND, flip_bits(stored_desc(), $urandom_range(4, 0)));
			else
				send_item(CMD_APPEND, rand_desc());
		end
		send_item(CMD_QUERY, stored_desc());
		send_item(CMD_QUERY, ~stored_desc());
		send_item(CMD_QUERY, flip_bits(stored_desc(), 3));

		drain_matches();
		repeat (IDLE_SETTLE) @(posedge clk);
		if (tracker.failures == 0 && tracker.outstanding() == 0)
			$display("hamming_knn_descriptor_matcher_tb: PASS");
		else
			$display("hamming_knn_descriptor_matcher_tb: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/hkm_pkg.sv
rtl/core/hkm_scan.sv
rtl/core/hamming_knn_descriptor_matcher.sv
tb/sv/hamming_knn_descriptor_matcher_tb.sv
